// File: rtl/utx_pkg.sv
package utx_pkg;

	localparam int BYTE_W    = 8;
	localparam int MAX_BYTES = 6;
	localparam int UNIT_W    = BYTE_W * (MAX_BYTES - 1);

	localparam logic [2:0] MODE_RAW   = 3'd0;
	localparam logic [2:0] MODE_UTF8  = 3'd1;
	localparam logic [2:0] MODE_U16LE = 3'd2;
	localparam logic [2:0] MODE_U16BE = 3'd3;
	localparam logic [2:0] MODE_U32LE = 3'd4;
	localparam logic [2:0] MODE_U32BE = 3'd5;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_LEAD  = 2'd1,
		ERR_RANGE = 2'd2
	} err_t;

	typedef struct packed {
		logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
		logic [2:0]                       count;
		err_t                             err;
	} job_t;

	function automatic logic [2:0] utf8_len(input logic [7:0] b);
		logic [2:0] len;
		priority if ((b & 8'h80) == 8'h00) len = 3'd1;
		else if ((b & 8'he0) == 8'hc0) len = 3'd2;
		else if ((b & 8'hf0) == 8'he0) len = 3'd3;
		else if ((b & 8'hf8) == 8'hf0) len = 3'd4;
		else if ((b & 8'hfc) == 8'hf8) len = 3'd5;
		else if ((b & 8'hfe) == 8'hfc) len = 3'd6;
		else len = 3'd0;
		return len;
	endfunction

endpackage

// File: rtl/utx_channels.sv
interface utx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       discard_partial;

	modport source (output valid, output in_byte, output discard_partial, input ready);
	modport sink (input valid, input in_byte, input discard_partial, output ready);
endinterface

interface utx_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_char;
	logic [1:0] error_code;

	modport source (output valid, output out_byte, output last_of_char, output error_code,
		input ready);
	modport sink (input valid, input out_byte, input last_of_char, input error_code,
		output ready);
endinterface

// File: rtl/utx_front.sv
module utx_front (
	input  logic             clk,
	input  logic             arst_n,
	utx_in_if.sink           src,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_wdata,
	input  logic             q_full,
	output logic             push,
	output utx_pkg::job_t    job
);

	logic [2:0]                 mode_q;
	logic [utx_pkg::UNIT_W-1:0] unit_q;
	logic [2:0]                 held_q;
	logic [2:0]                 expected_q;

	logic [utx_pkg::UNIT_W-1:0] unit_d;
	logic [2:0]                 held_d;
	logic [2:0]                 expected_d;
	logic                       push_d;
	logic                       accept;
	logic [7:0]                 b;
	logic [47:0]                merged;
	logic [2:0]                 held_inc;
	logic [2:0]                 lead_len;
	logic [2:0]                 unit_size;
	logic [31:0]                data;

	assign src.ready = !q_full;
	assign accept    = src.valid && src.ready;
	assign push      = accept && push_d;
	assign b         = src.in_byte;
	assign held_inc  = held_q + 3'd1;
	assign lead_len  = utx_pkg::utf8_len(b);
	assign merged    = {8'b0, (held_q == 3'd0) ? '0 : unit_q} | ({40'b0, b} << {held_q, 3'b000});
	assign unit_size = (mode_q == utx_pkg::MODE_U16LE || mode_q == utx_pkg::MODE_U16BE) ?
		3'd2 : 3'd4;

	always_comb begin
		unique case (mode_q)
			utx_pkg::MODE_U16LE: data = {16'b0, merged[15:8], merged[7:0]};
			utx_pkg::MODE_U16BE: data = {16'b0, merged[7:0], merged[15:8]};
			utx_pkg::MODE_U32LE: data = merged[31:0];
			default:             data = {merged[7:0], merged[15:8], merged[23:16], merged[31:24]};
		endcase
	end

	always_comb begin
		unit_d     = unit_q;
		held_d     = held_q;
		expected_d = expected_q;
		push_d     = 1'b0;
		job.bytes  = {40'b0, b};
		job.count  = 3'd1;
		job.err    = utx_pkg::ERR_NONE;
		if (src.discard_partial) begin
			held_d     = 3'd0;
			expected_d = 3'd0;
		end else begin
			unique case (mode_q)
				utx_pkg::MODE_UTF8: begin
					if (held_q == 3'd0) begin
						if (lead_len == 3'd0) begin
							push_d  = 1'b1;
							job.err = utx_pkg::ERR_LEAD;
						end else if (lead_len == 3'd1) begin
							push_d = 1'b1;
						end else begin
							unit_d     = {32'b0, b};
							held_d     = 3'd1;
							expected_d = lead_len;
						end
					end else if (held_inc < expected_q) begin
						unit_d = merged[utx_pkg::UNIT_W-1:0];
						held_d = held_inc;
					end else begin
						push_d     = 1'b1;
						job.bytes  = merged;
						job.count  = expected_q;
						held_d     = 3'd0;
						expected_d = 3'd0;
					end
				end
				utx_pkg::MODE_U16LE, utx_pkg::MODE_U16BE,
				utx_pkg::MODE_U32LE, utx_pkg::MODE_U32BE: begin
					if (held_inc < unit_size) begin
						unit_d     = merged[utx_pkg::UNIT_W-1:0];
						held_d     = held_inc;
						expected_d = unit_size;
					end else begin
						push_d     = 1'b1;
						held_d     = 3'd0;
						expected_d = 3'd0;
						if (data[31:16] != 16'b0) begin
							job.err = utx_pkg::ERR_RANGE;
						end else if (data[15:7] == 9'b0) begin
							job.bytes = {40'b0, data[7:0]};
						end else if (data[15:11] == 5'b0) begin
							job.bytes = {32'b0, 2'b10, data[5:0], 3'b110, data[10:6]};
							job.count = 3'd2;
						end else begin
							job.bytes = {24'b0, 2'b10, data[5:0], 2'b10, data[11:6],
								4'b1110, data[15:12]};
							job.count = 3'd3;
						end
					end
				end
				default: begin
					push_d = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= utx_pkg::MODE_RAW;
			unit_q     <= '0;
			held_q     <= 3'd0;
			expected_q <= 3'd0;
		end else if (cfg_we) begin
			mode_q     <= cfg_wdata;
			held_q     <= 3'd0;
			expected_q <= 3'd0;
		end else if (accept) begin
			unit_q     <= unit_d;
			held_q     <= held_d;
			expected_q <= expected_d;
		end
	end

endmodule

// File: rtl/utx_queue.sv
module utx_queue #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  utx_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output utx_pkg::job_t head_job,
	output logic          empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	utx_pkg::job_t    entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = count_q == CNT_W'(DEPTH);
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_job = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/utx_back.sv
module utx_back (
	input  logic          clk,
	input  logic          arst_n,
	input  utx_pkg::job_t head_job,
	input  logic          empty,
	output logic          pop,
	utx_out_if.source     dst
);

	logic [2:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic [1:0] err_q;
	logic       load;
	logic       is_last;

	assign load    = !empty && (!valid_q || dst.ready);
	assign is_last = idx_q == (head_job.count - 3'd1);
	assign pop     = load && is_last;

	assign dst.valid        = valid_q;
	assign dst.out_byte     = byte_q;
	assign dst.last_of_char = last_q;
	assign dst.error_code   = err_q;

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= head_job.bytes[idx_q];
			last_q <= is_last;
			err_q  <= head_job.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 3'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= is_last ? 3'd0 : idx_q + 3'd1;
		end else if (dst.ready) begin
			valid_q <= 1'b0;
		end
	end

endmodule

// File: rtl/utf16_utf32_to_utf8_transcoder_unit.sv
// A word that completes a character is written to the job queue and then to the output
// register before its first UTF-8 byte is shown. One input word per cycle while the job queue
// has room, one output word per cycle while dst.ready is high; a character of n bytes holds
// the output side for n output words.
// Reset clears the mode to raw, the partial unit, the job queue and the output valid flag.
module utf16_utf32_to_utf8_transcoder_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	utx_in_if.sink     src,
	utx_out_if.source  dst,
	input  logic       cfg_we,
	input  logic [2:0] cfg_wdata
);

	logic          push;
	logic          pop;
	logic          q_full;
	logic          q_empty;
	utx_pkg::job_t push_job;
	utx_pkg::job_t head_job;

	utx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src       (src),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.push      (push),
		.job       (push_job)
	);

	utx_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (pop),
		.head_job (head_job),
		.empty    (q_empty)
	);

	utx_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_job (head_job),
		.empty    (q_empty),
		.pop      (pop),
		.dst      (dst)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(src.valid && src.ready && push) |-> !q_full)
		else $error("job pushed into a full queue");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("job popped from an empty queue");

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(dst.valid && dst.error_code != 2'd0) |-> dst.last_of_char)
		else $error("error word not marked as last of character");

	a_ready_follows_queue: assert property (@(posedge clk) disable iff (!arst_n)
		q_empty |-> src.ready)
		else $error("input stalled while the job queue is empty");

endmodule
